### rtl/spherical_to_cartesian_defines.svh
// Assertion macros shared by the spherical-to-Cartesian RTL.
`ifndef SPHERICAL_TO_CARTESIAN_DEFINES_SVH
`define SPHERICAL_TO_CARTESIAN_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on aclk, off while aresetn is low.
`define STC_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("stc assertion failed");
// Next-cycle implication, checked on aclk, off while aresetn is low.
`define STC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stc assertion failed");
`else
`define STC_ASSERT_IMPL(name, ante, cons)
`define STC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### rtl/stc_pkg.sv
// Package: sizes, CORDIC constants and inter-stage types for the converter.
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int RADIUS_BITS   = 24;
    localparam int ANGLE_BITS    = 16;

    // atan table depth; stages beyond it are not built
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_RUN    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;

    // internal phase (full turn = 2^32), Q30 sine/cosine, residual angle width
    localparam int PHASE_BITS = 32;
    localparam int TRIG_W     = 32;
    localparam int RESID_W    = 33;
    localparam int FRAC_BITS  = 30;
    localparam int HALF_Q30   = 536870912;

    localparam int COORD_W    = RADIUS_BITS + 1;
    localparam int S_DATA_W   = ((RADIUS_BITS + 2 * ANGLE_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = ((3 * COORD_W + 7) / 8) * 8;

    // CORDIC gain 0.60725... in Q30, loaded as the start value of x
    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 32'sd652032874;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    // CORDIC result handed to the multiplier pipeline
    typedef struct packed {
        logic                     valid;
        logic [RADIUS_BITS-1:0]   radius;
        logic signed [TRIG_W-1:0] sin_t;
        logic signed [TRIG_W-1:0] cos_t;
        logic signed [TRIG_W-1:0] sin_p;
        logic signed [TRIG_W-1:0] cos_p;
    } stc_trig_t;

    // one finished point
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } stc_xyz_t;

    typedef struct packed {
        logic     valid;
        stc_xyz_t xyz;
    } stc_coord_t;

endpackage

`default_nettype wire

### rtl/stc_cordic.sv
// Two-lane unrolled CORDIC pipeline: sin/cos of the polar and azimuth angles.
`timescale 1ns / 1ps
`default_nettype none
`include "spherical_to_cartesian_defines.svh"

module stc_cordic import stc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  logic                   in_valid,
    input  logic [RADIUS_BITS-1:0] in_radius,
    input  logic [ANGLE_BITS-1:0]  in_polar,
    input  logic [ANGLE_BITS-1:0]  in_azimuth,
    output stc_trig_t              out_trig
);

    localparam int LANES = 2;
    // residual after the last stage stays inside twice the last atan step
    localparam logic signed [RESID_W-1:0] RESID_LIM =
        RESID_W'(ATAN_TAB[CORDIC_RUN-1]) <<< 1;

    logic [ANGLE_BITS-1:0] angle_in [LANES];

    logic signed [TRIG_W-1:0]  x_reg    [LANES][CORDIC_RUN+1];
    logic signed [TRIG_W-1:0]  y_reg    [LANES][CORDIC_RUN+1];
    logic signed [RESID_W-1:0] z_reg    [LANES][CORDIC_RUN+1];
    logic                      flip_reg [LANES][CORDIC_RUN+1];
    logic signed [TRIG_W-1:0]  x_next   [LANES][CORDIC_RUN+1];
    logic signed [TRIG_W-1:0]  y_next   [LANES][CORDIC_RUN+1];
    logic signed [RESID_W-1:0] z_next   [LANES][CORDIC_RUN+1];
    logic                      flip_next[LANES][CORDIC_RUN+1];

    logic                      valid_reg [CORDIC_RUN+1];
    logic [RADIUS_BITS-1:0]    rad_reg   [CORDIC_RUN+1];

    stc_trig_t                 trig_reg;

    assign angle_in[0] = in_polar;
    assign angle_in[1] = in_azimuth;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        // entry: place angle in the top phase bits, fold quadrants 2 and 3 by pi
        logic [PHASE_BITS-1:0] phase;
        logic                  turn;

        assign phase = {angle_in[l], {(PHASE_BITS - ANGLE_BITS){1'b0}}};
        assign turn  = phase[PHASE_BITS-1] ^ phase[PHASE_BITS-2];

        assign x_next[l][0]    = GAIN_Q30;
        assign y_next[l][0]    = '0;
        assign z_next[l][0]    = RESID_W'($signed({phase[PHASE_BITS-1] ^ turn,
                                                    phase[PHASE_BITS-2:0]}));
        assign flip_next[l][0] = turn;

        // one micro-rotation per register stage
        for (genvar k = 0; k < CORDIC_RUN; k++) begin : g_stage
            localparam logic signed [RESID_W-1:0] ATAN_K = RESID_W'(ATAN_TAB[k]);
            logic signed [TRIG_W-1:0] xs;
            logic signed [TRIG_W-1:0] ys;

            assign xs = x_reg[l][k] >>> k;
            assign ys = y_reg[l][k] >>> k;

            always_comb begin
                if (!z_reg[l][k][RESID_W-1]) begin
                    x_next[l][k+1] = x_reg[l][k] - ys;
                    y_next[l][k+1] = y_reg[l][k] + xs;
                    z_next[l][k+1] = z_reg[l][k] - ATAN_K;
                end else begin
                    x_next[l][k+1] = x_reg[l][k] + ys;
                    y_next[l][k+1] = y_reg[l][k] - xs;
                    z_next[l][k+1] = z_reg[l][k] + ATAN_K;
                end
            end

            assign flip_next[l][k+1] = flip_reg[l][k];
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= CORDIC_RUN; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < CORDIC_RUN; k++) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            rad_reg[0] <= in_radius;
            for (int k = 0; k < CORDIC_RUN; k++) begin
                rad_reg[k+1] <= rad_reg[k];
            end
            for (int l = 0; l < LANES; l++) begin
                for (int k = 0; k <= CORDIC_RUN; k++) begin
                    x_reg[l][k]    <= x_next[l][k];
                    y_reg[l][k]    <= y_next[l][k];
                    z_reg[l][k]    <= z_next[l][k];
                    flip_reg[l][k] <= flip_next[l][k];
                end
            end
        end
    end

    // output stage: undo the pi fold by negating both results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_reg.valid <= 1'b0;
        end else if (adv) begin
            trig_reg.valid  <= valid_reg[CORDIC_RUN];
            trig_reg.radius <= rad_reg[CORDIC_RUN];
            trig_reg.sin_t  <= flip_reg[0][CORDIC_RUN] ? -y_reg[0][CORDIC_RUN]
                                                       :  y_reg[0][CORDIC_RUN];
            trig_reg.cos_t  <= flip_reg[0][CORDIC_RUN] ? -x_reg[0][CORDIC_RUN]
                                                       :  x_reg[0][CORDIC_RUN];
            trig_reg.sin_p  <= flip_reg[1][CORDIC_RUN] ? -y_reg[1][CORDIC_RUN]
                                                       :  y_reg[1][CORDIC_RUN];
            trig_reg.cos_p  <= flip_reg[1][CORDIC_RUN] ? -x_reg[1][CORDIC_RUN]
                                                       :  x_reg[1][CORDIC_RUN];
        end
    end

    assign out_trig = trig_reg;

    // residual angle has converged at the last stage
    `STC_ASSERT_IMPL(a_polar_resid, valid_reg[CORDIC_RUN],
        (z_reg[0][CORDIC_RUN] <= RESID_LIM) && (z_reg[0][CORDIC_RUN] >= -RESID_LIM))
    `STC_ASSERT_IMPL(a_azim_resid, valid_reg[CORDIC_RUN],
        (z_reg[1][CORDIC_RUN] <= RESID_LIM) && (z_reg[1][CORDIC_RUN] >= -RESID_LIM))
    // an item leaving the last stage reaches the output register
    `STC_ASSERT_NEXT(a_valid_flow, adv && valid_reg[CORDIC_RUN], trig_reg.valid)

endmodule

`default_nettype wire

### rtl/stc_mult.sv
// Product pipeline: trig products, radius scaling, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none
`include "spherical_to_cartesian_defines.svh"

module stc_mult import stc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  stc_trig_t  in_trig,
    output stc_coord_t out_coord
);

    localparam int PW = 2 * TRIG_W;
    localparam int QW = RADIUS_BITS + 1 + TRIG_W;
    localparam logic signed [PW-1:0] HALF_P = PW'(HALF_Q30);
    localparam logic signed [QW-1:0] HALF_Q = QW'(HALF_Q30);
    localparam logic signed [QW-1:0] LIM    = (QW'(1) <<< RADIUS_BITS) - QW'(1);
    localparam logic signed [COORD_W-1:0] MOST_NEG = {1'b1, {(COORD_W-1){1'b0}}};

    // stage 1: sin(theta)*cos(phi), sin(theta)*sin(phi)
    logic                     v1_reg;
    logic signed [PW-1:0]     pc_reg, ps_reg;
    logic signed [TRIG_W-1:0] ct1_reg;
    logic [RADIUS_BITS-1:0]   r1_reg;
    // stage 2: back to Q30
    logic                     v2_reg;
    logic signed [TRIG_W-1:0] sxc_reg, sxs_reg, ct2_reg;
    logic [RADIUS_BITS-1:0]   r2_reg;
    // stage 3: radius products
    logic                     v3_reg;
    logic signed [QW-1:0]     qx_reg, qy_reg, qz_reg;
    // stage 4: rounded and saturated coordinates
    logic                     v4_reg;
    stc_xyz_t                 xyz_reg;

    logic signed [PW-1:0]     pc_rnd, ps_rnd;
    logic signed [RADIUS_BITS:0] r_s;

    function automatic logic signed [COORD_W-1:0] round_sat(logic signed [QW-1:0] q);
        logic signed [QW-1:0] v;
        v = (q + HALF_Q) >>> FRAC_BITS;
        if (v > LIM) begin
            v = LIM;
        end else if (v < -LIM) begin
            v = -LIM;
        end
        return v[COORD_W-1:0];
    endfunction

    assign pc_rnd = (pc_reg + HALF_P) >>> FRAC_BITS;
    assign ps_rnd = (ps_reg + HALF_P) >>> FRAC_BITS;
    assign r_s    = $signed({1'b0, r2_reg});

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_trig.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            pc_reg  <= PW'(in_trig.sin_t) * PW'(in_trig.cos_p);
            ps_reg  <= PW'(in_trig.sin_t) * PW'(in_trig.sin_p);
            ct1_reg <= in_trig.cos_t;
            r1_reg  <= in_trig.radius;

            sxc_reg <= pc_rnd[TRIG_W-1:0];
            sxs_reg <= ps_rnd[TRIG_W-1:0];
            ct2_reg <= ct1_reg;
            r2_reg  <= r1_reg;

            qx_reg  <= QW'(r_s) * QW'(sxc_reg);
            qy_reg  <= QW'(r_s) * QW'(sxs_reg);
            qz_reg  <= QW'(r_s) * QW'(ct2_reg);

            xyz_reg.x <= round_sat(qx_reg);
            xyz_reg.y <= round_sat(qy_reg);
            xyz_reg.z <= round_sat(qz_reg);
        end
    end

    assign out_coord = {v4_reg, xyz_reg};

    // saturation never produces the most negative code
    `STC_ASSERT_IMPL(a_sat_range, v4_reg,
        (xyz_reg.x != MOST_NEG) && (xyz_reg.y != MOST_NEG) && (xyz_reg.z != MOST_NEG))

endmodule

`default_nettype wire

### rtl/stc_out_skid.sv
// Output register with a skid slot; decouples pipeline advance from m_tready.
`timescale 1ns / 1ps
`default_nettype none
`include "spherical_to_cartesian_defines.svh"

module stc_out_skid import stc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  stc_coord_t in_beat,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output stc_xyz_t   out_xyz
);

    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    stc_xyz_t out_data_reg, out_data_next;
    stc_xyz_t skid_data_reg, skid_data_next;
    logic     take;

    // the pipeline moves only while the skid slot is free
    assign in_ready = !skid_valid_reg;
    assign take     = in_beat.valid && in_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            // output slot frees up: refill from skid first, then from the pipe
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next  = take;
                out_data_next   = in_beat.xyz;
            end
        end else if (take) begin
            // receiver stalled: park the beat
            skid_valid_next = 1'b1;
            skid_data_next  = in_beat.xyz;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_xyz   = out_data_reg;

    // a parked beat always sits behind a held output beat
    `STC_ASSERT_IMPL(a_skid_behind, skid_valid_reg, out_valid_reg)
    // draining the output moves the parked beat forward
    `STC_ASSERT_NEXT(a_skid_drain, out_valid_reg && out_ready && skid_valid_reg,
        out_valid_reg && !skid_valid_reg)

endmodule

`default_nettype wire

### rtl/spherical_to_cartesian.sv
// Spherical (r, theta, phi) to Cartesian (x, y, z) converter, top level.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata, one point each: radius
//   (unsigned Q8.16) and two binary angles (full turn = 65536). Result beats
//   leave on m_tvalid/m_tready/m_tdata, one per input, in order, as signed
//   Q8.16 coordinates rounded and saturated to +-(2^24 - 1).
//   Throughput: one point per cycle while m_tready stays high. The pipeline
//   is two unrolled 16-stage CORDIC lanes followed by two multiply levels.
//   Stages: an accepted beat passes 1 entry stage, 16 CORDIC stages, 1 sign
//   fix, 4 product stages and the output register before m_tvalid rises.
//   Reset: aresetn low at a clock edge empties the pipeline and the output;
//   no beat is in flight afterwards.
//   Stall: when m_tready is low the output beat holds; one more beat parks
//   in a skid slot, then s_tready drops and the whole pipeline freezes.
//   s_tready is a register output and does not depend on m_tready directly.
`timescale 1ns / 1ps
`default_nettype none

module spherical_to_cartesian import stc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // s_tdata: radius[23:0], polar_angle[39:24], azimuth_angle[55:40]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // m_tdata: x_coord[24:0], y_coord[49:25], z_coord[74:50], zero fill above
    output logic [M_DATA_W-1:0] m_tdata
);

    logic       pipe_adv;
    stc_trig_t  trig;
    stc_coord_t coord;
    stc_xyz_t   xyz;

    assign s_tready = pipe_adv;

    stc_cordic u_cordic (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (pipe_adv),
        .in_valid   (s_tvalid),
        .in_radius  (s_tdata[RADIUS_BITS-1:0]),
        .in_polar   (s_tdata[RADIUS_BITS +: ANGLE_BITS]),
        .in_azimuth (s_tdata[RADIUS_BITS + ANGLE_BITS +: ANGLE_BITS]),
        .out_trig   (trig)
    );

    stc_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (pipe_adv),
        .in_trig   (trig),
        .out_coord (coord)
    );

    stc_out_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_beat   (coord),
        .in_ready  (pipe_adv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_xyz   (xyz)
    );

    // pack x lowest, zero fill to whole bytes
    assign m_tdata = M_DATA_W'({xyz.z, xyz.y, xyz.x});

endmodule

`default_nettype wire
